@@ rtl/fuzzy_membership_function_core_assert.svh @@
// ----------------------------------------------------------------------------
// Fuzzy membership function core: assertion macros
// Clocked implication checks shared by the assertion checker.
// ----------------------------------------------------------------------------
`ifndef FUZZY_MEMBERSHIP_FUNCTION_CORE_ASSERT_SVH
`define FUZZY_MEMBERSHIP_FUNCTION_CORE_ASSERT_SVH

// same-cycle implication
`define FMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fmf assertion failed");

// next-cycle implication
`define FMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fmf assertion failed");

`endif

@@ rtl/fmf_pkg.sv @@
// ----------------------------------------------------------------------------
// fmf_pkg
// Shared constants and types of the fuzzy membership function core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmf_pkg;

    localparam int SAMPLE_WIDTH_DEF     = 16;
    localparam int DEGREE_FRAC_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_SHAPE = 3'd0;
    localparam logic [2:0] REG_A     = 3'd1;
    localparam logic [2:0] REG_B     = 3'd2;
    localparam logic [2:0] REG_C     = 3'd3;
    localparam logic [2:0] REG_D     = 3'd4;
    localparam logic [2:0] REG_M     = 3'd5;

    localparam logic [1:0] SHAPE_TRI   = 2'd0;
    localparam logic [1:0] SHAPE_GAMMA = 2'd1;
    localparam logic [1:0] SHAPE_S     = 2'd2;
    localparam logic [1:0] SHAPE_TRAP  = 2'd3;

    localparam logic [1:0] SEG_OUTSIDE = 2'd0;
    localparam logic [1:0] SEG_RISE    = 2'd1;
    localparam logic [1:0] SEG_TOP     = 2'd2;
    localparam logic [1:0] SEG_FALL    = 2'd3;

    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_LIN,
        KIND_SQ,
        KIND_SQ_UPPER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] seg;
    } t_ctl;

endpackage

@@ rtl/fmf_classify.sv @@
// ----------------------------------------------------------------------------
// fmf_classify
// Two stages: breakpoint compares and differences, then squaring for S.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmf_classify #(
    parameter int SAMPLE_WIDTH = fmf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [SAMPLE_WIDTH-1:0]     i_x,
    input  logic [1:0]                  i_shape,
    input  logic [SAMPLE_WIDTH-1:0]     i_a,
    input  logic [SAMPLE_WIDTH-1:0]     i_b,
    input  logic [SAMPLE_WIDTH-1:0]     i_c,
    input  logic [SAMPLE_WIDTH-1:0]     i_d,
    input  logic [SAMPLE_WIDTH-1:0]     i_m,
    input  logic                        i_ready,
    output logic                        o_ready,
    output logic                        o_valid,
    output fmf_pkg::t_ctl               o_ctl,
    output logic [2*SAMPLE_WIDTH+1:0]   o_num,
    output logic [2*SAMPLE_WIDTH+1:0]   o_den
);

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int DW     = 2 * SAMPLE_WIDTH + 2;

    logic signed [DIFF_W-1:0] xe, ae, be, ce, de, me;
    logic signed [DIFF_W:0]   x2, ac;

    fmf_pkg::t_ctl       n1_ctl;
    logic [DIFF_W-1:0]   n1_num, n1_den;

    logic                r1_valid;
    fmf_pkg::t_ctl       r1_ctl;
    logic [DIFF_W-1:0]   r1_num, r1_den;

    logic                r2_valid;
    fmf_pkg::t_ctl       r2_ctl;
    logic [DW-1:0]       r2_num, r2_den;
    logic [DW-1:0]       n2_num, n2_den;

    logic                rdy1, rdy2;

    assign xe = $signed({i_x[SAMPLE_WIDTH-1], i_x});
    assign ae = $signed({i_a[SAMPLE_WIDTH-1], i_a});
    assign be = $signed({i_b[SAMPLE_WIDTH-1], i_b});
    assign ce = $signed({i_c[SAMPLE_WIDTH-1], i_c});
    assign de = $signed({i_d[SAMPLE_WIDTH-1], i_d});
    assign me = $signed({i_m[SAMPLE_WIDTH-1], i_m});
    assign x2 = $signed({xe, 1'b0});
    assign ac = $signed({ae[DIFF_W-1], ae}) + $signed({ce[DIFF_W-1], ce});

    always_comb begin
        n1_ctl.kind = fmf_pkg::KIND_ZERO;
        n1_ctl.seg  = fmf_pkg::SEG_OUTSIDE;
        n1_num      = '0;
        n1_den      = '0;
        case (i_shape)
            fmf_pkg::SHAPE_TRI: begin
                if (xe <= ae || xe >= be) begin
                    n1_ctl.kind = fmf_pkg::KIND_ZERO;
                end else if (xe <= me) begin
                    n1_ctl.kind = fmf_pkg::KIND_LIN;
                    n1_ctl.seg  = fmf_pkg::SEG_RISE;
                    n1_num      = DIFF_W'(xe - ae);
                    n1_den      = DIFF_W'(me - ae);
                end else begin
                    n1_ctl.kind = fmf_pkg::KIND_LIN;
                    n1_ctl.seg  = fmf_pkg::SEG_FALL;
                    n1_num      = DIFF_W'(be - xe);
                    n1_den      = DIFF_W'(be - me);
                end
            end
            fmf_pkg::SHAPE_GAMMA: begin
                if (xe <= ae) begin
                    n1_ctl.kind = fmf_pkg::KIND_ZERO;
                end else if (xe < me) begin
                    n1_ctl.kind = fmf_pkg::KIND_LIN;
                    n1_ctl.seg  = fmf_pkg::SEG_RISE;
                    n1_num      = DIFF_W'(xe - ae);
                    n1_den      = DIFF_W'(me - ae);
                end else begin
                    n1_ctl.kind = fmf_pkg::KIND_ONE;
                    n1_ctl.seg  = fmf_pkg::SEG_TOP;
                end
            end
            fmf_pkg::SHAPE_S: begin
                if (xe < ae) begin
                    n1_ctl.kind = fmf_pkg::KIND_ZERO;
                end else if (x2 <= ac) begin
                    n1_ctl.seg = fmf_pkg::SEG_RISE;
                    if (ce <= ae) begin
                        n1_ctl.kind = fmf_pkg::KIND_ZERO;
                    end else begin
                        n1_ctl.kind = fmf_pkg::KIND_SQ;
                        n1_num      = DIFF_W'(xe - ae);
                        n1_den      = DIFF_W'(ce - ae);
                    end
                end else if (xe <= ce) begin
                    n1_ctl.kind = fmf_pkg::KIND_SQ_UPPER;
                    n1_ctl.seg  = fmf_pkg::SEG_RISE;
                    n1_num      = DIFF_W'(ce - xe);
                    n1_den      = DIFF_W'(ce - ae);
                end else begin
                    n1_ctl.kind = fmf_pkg::KIND_ONE;
                    n1_ctl.seg  = fmf_pkg::SEG_TOP;
                end
            end
            default: begin
                if (xe <= ae || xe >= de) begin
                    n1_ctl.kind = fmf_pkg::KIND_ZERO;
                end else if (xe <= be) begin
                    n1_ctl.kind = fmf_pkg::KIND_LIN;
                    n1_ctl.seg  = fmf_pkg::SEG_RISE;
                    n1_num      = DIFF_W'(xe - ae);
                    n1_den      = DIFF_W'(be - ae);
                end else if (xe <= ce) begin
                    n1_ctl.kind = fmf_pkg::KIND_ONE;
                    n1_ctl.seg  = fmf_pkg::SEG_TOP;
                end else begin
                    n1_ctl.kind = fmf_pkg::KIND_LIN;
                    n1_ctl.seg  = fmf_pkg::SEG_FALL;
                    n1_num      = DIFF_W'(de - xe);
                    n1_den      = DIFF_W'(de - ce);
                end
            end
        endcase
    end

    // squared ratio for the S shape, plain ratio otherwise
    always_comb begin
        if (r1_ctl.kind == fmf_pkg::KIND_SQ || r1_ctl.kind == fmf_pkg::KIND_SQ_UPPER) begin
            n2_num = DW'(r1_num) * DW'(r1_num);
            n2_den = DW'(r1_den) * DW'(r1_den);
        end else begin
            n2_num = DW'(r1_num);
            n2_den = DW'(r1_den);
        end
    end

    assign rdy2    = !r2_valid || i_ready;
    assign rdy1    = !r1_valid || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_valid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_ctl <= n1_ctl;
            r1_num <= n1_num;
            r1_den <= n1_den;
        end
        if (rdy2) begin
            r2_ctl <= r1_ctl;
            r2_num <= n2_num;
            r2_den <= n2_den;
        end
    end

    assign o_valid = r2_valid;
    assign o_ctl   = r2_ctl;
    assign o_num   = r2_num;
    assign o_den   = r2_den;

endmodule

@@ rtl/fmf_divider.sv @@
// ----------------------------------------------------------------------------
// fmf_divider
// Pipelined restoring divider, one quotient bit per stage.
// Quotient is floor(num * 2^(DEGREE_FRAC_BITS+2) / den) for num <= den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmf_divider #(
    parameter int SAMPLE_WIDTH     = fmf_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEGREE_FRAC_BITS = fmf_pkg::DEGREE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  fmf_pkg::t_ctl                   i_ctl,
    input  logic [2*SAMPLE_WIDTH+1:0]       i_num,
    input  logic [2*SAMPLE_WIDTH+1:0]       i_den,
    input  logic                            i_ready,
    output logic                            o_ready,
    output logic                            o_valid,
    output fmf_pkg::t_ctl                   o_ctl,
    output logic [DEGREE_FRAC_BITS+2:0]     o_quo
);

    localparam int DW = 2 * SAMPLE_WIDTH + 2;
    localparam int QW = DEGREE_FRAC_BITS + 3;
    localparam int NS = QW;

    logic [NS-1:0]   r_valid;
    fmf_pkg::t_ctl   r_ctl [NS];
    logic [DW-1:0]   r_den [NS];
    logic [DW-1:0]   r_rem [NS];
    logic [QW-1:0]   r_quo [NS];

    logic [DW-1:0]   n_rem [NS];
    logic [QW-1:0]   n_quo [NS];
    logic [NS:0]     rdy;

    always_comb begin
        logic          ge;
        logic [DW:0]   sh;
        ge = i_num >= i_den;
        n_rem[0] = ge ? i_num - i_den : i_num;
        n_quo[0] = QW'(ge);
        for (int k = 1; k < NS; k++) begin
            sh       = {r_rem[k-1], 1'b0};
            ge       = sh >= {1'b0, r_den[k-1]};
            n_rem[k] = ge ? DW'(sh - {1'b0, r_den[k-1]}) : DW'(sh);
            n_quo[k] = {r_quo[k-1][QW-2:0], ge};
        end
    end

    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_ctl[0] <= i_ctl;
            r_den[0] <= i_den;
            r_rem[0] <= n_rem[0];
            r_quo[0] <= n_quo[0];
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                r_ctl[k] <= r_ctl[k-1];
                r_den[k] <= r_den[k-1];
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_ctl   = r_ctl[NS-1];
    assign o_quo   = r_quo[NS-1];

endmodule

@@ rtl/fmf_finish.sv @@
// ----------------------------------------------------------------------------
// fmf_finish
// Rounding, S upper-part complement, saturation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmf_finish #(
    parameter int DEGREE_FRAC_BITS = fmf_pkg::DEGREE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  fmf_pkg::t_ctl                   i_ctl,
    input  logic [DEGREE_FRAC_BITS+2:0]     i_quo,
    input  logic                            i_stall,
    output logic                            o_ready,
    output logic                            o_valid,
    output logic [DEGREE_FRAC_BITS:0]       o_degree,
    output logic [1:0]                      o_segment
);

    localparam int QW = DEGREE_FRAC_BITS + 3;
    localparam logic [QW-1:0] ONE = QW'(1) << DEGREE_FRAC_BITS;

    logic [QW-1:0]              t_sq, t_lin, deg;
    logic [DEGREE_FRAC_BITS:0]  n_degree;

    logic                       r_valid;
    logic [DEGREE_FRAC_BITS:0]  r_degree;
    logic [1:0]                 r_segment;

    // quotient carries two guard bits beyond the linear result
    assign t_sq  = (i_quo + QW'(1)) >> 1;
    assign t_lin = ((i_quo >> 1) + QW'(1)) >> 1;

    always_comb begin
        case (i_ctl.kind)
            fmf_pkg::KIND_ZERO:     deg = '0;
            fmf_pkg::KIND_ONE:      deg = ONE;
            fmf_pkg::KIND_LIN:      deg = t_lin;
            fmf_pkg::KIND_SQ:       deg = t_sq;
            fmf_pkg::KIND_SQ_UPPER: deg = (t_sq >= ONE) ? '0 : ONE - t_sq;
            default:                deg = '0;
        endcase
        n_degree = (deg > ONE) ? ONE[DEGREE_FRAC_BITS:0] : deg[DEGREE_FRAC_BITS:0];
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_degree  <= n_degree;
            r_segment <= i_ctl.seg;
        end
    end

    assign o_valid   = r_valid;
    assign o_degree  = r_degree;
    assign o_segment = r_segment;

endmodule

@@ rtl/fuzzy_membership_function_core.sv @@
// ----------------------------------------------------------------------------
// fuzzy_membership_function_core
// Fuzzy membership degree of a signed sample for a triangular, gamma, S or
// trapezoidal shape, selected and shaped by APB registers.
//
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+-------------------------
//   sample   | i_valid  | o_stall  | i_sample_x
//   degree   | o_valid  | i_stall  | o_degree, o_segment
//   config   | APB      | -        | paddr, pwdata, prdata
//
// One beat per clock while the output is not stalled. Pipeline: two compare and
// square stages, one divider stage per quotient bit, one output stage.
// Stalls collapse bubbles stage by stage; o_stall rises only when every
// stage holds a beat and the output beat is stalled.
// Synchronous active-low reset clears valid bits and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fuzzy_membership_function_core #(
    parameter int SAMPLE_WIDTH     = fmf_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEGREE_FRAC_BITS = fmf_pkg::DEGREE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fmf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [fmf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [fmf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [SAMPLE_WIDTH-1:0]             i_sample_x,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [DEGREE_FRAC_BITS:0]           o_degree,
    output logic [1:0]                          o_segment
);

    localparam int DW = 2 * SAMPLE_WIDTH + 2;
    localparam int QW = DEGREE_FRAC_BITS + 3;

    logic [1:0]               r_shape;
    logic [SAMPLE_WIDTH-1:0]  r_a, r_b, r_c, r_d, r_m;
    logic [2:0]               reg_idx;
    logic                     wr_en;

    logic                     cls_ready, cls_valid;
    fmf_pkg::t_ctl            cls_ctl;
    logic [DW-1:0]            cls_num, cls_den;

    logic                     div_ready, div_valid;
    fmf_pkg::t_ctl            div_ctl;
    logic [QW-1:0]            div_quo;

    logic                     fin_ready;

    assign pready  = 1'b1;
    assign reg_idx = paddr[fmf_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= fmf_pkg::SHAPE_TRI;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
            r_m     <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                fmf_pkg::REG_SHAPE: r_shape <= pwdata[1:0];
                fmf_pkg::REG_A:     r_a     <= pwdata[SAMPLE_WIDTH-1:0];
                fmf_pkg::REG_B:     r_b     <= pwdata[SAMPLE_WIDTH-1:0];
                fmf_pkg::REG_C:     r_c     <= pwdata[SAMPLE_WIDTH-1:0];
                fmf_pkg::REG_D:     r_d     <= pwdata[SAMPLE_WIDTH-1:0];
                fmf_pkg::REG_M:     r_m     <= pwdata[SAMPLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fmf_pkg::REG_SHAPE: prdata = fmf_pkg::CFG_DATA_W'(r_shape);
            fmf_pkg::REG_A:     prdata = fmf_pkg::CFG_DATA_W'(r_a);
            fmf_pkg::REG_B:     prdata = fmf_pkg::CFG_DATA_W'(r_b);
            fmf_pkg::REG_C:     prdata = fmf_pkg::CFG_DATA_W'(r_c);
            fmf_pkg::REG_D:     prdata = fmf_pkg::CFG_DATA_W'(r_d);
            fmf_pkg::REG_M:     prdata = fmf_pkg::CFG_DATA_W'(r_m);
            default:            prdata = '0;
        endcase
    end

    fmf_classify #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_x     (i_sample_x),
        .i_shape (r_shape),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_m     (r_m),
        .i_ready (div_ready),
        .o_ready (cls_ready),
        .o_valid (cls_valid),
        .o_ctl   (cls_ctl),
        .o_num   (cls_num),
        .o_den   (cls_den)
    );

    fmf_divider #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .DEGREE_FRAC_BITS (DEGREE_FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .i_ctl   (cls_ctl),
        .i_num   (cls_num),
        .i_den   (cls_den),
        .i_ready (fin_ready),
        .o_ready (div_ready),
        .o_valid (div_valid),
        .o_ctl   (div_ctl),
        .o_quo   (div_quo)
    );

    fmf_finish #(
        .DEGREE_FRAC_BITS (DEGREE_FRAC_BITS)
    ) u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (div_valid),
        .i_ctl     (div_ctl),
        .i_quo     (div_quo),
        .i_stall   (i_stall),
        .o_ready   (fin_ready),
        .o_valid   (o_valid),
        .o_degree  (o_degree),
        .o_segment (o_segment)
    );

    assign o_stall = !cls_ready;

endmodule

@@ rtl/fmf_checker.sv @@
// ----------------------------------------------------------------------------
// fmf_checker
// Port-level checks of the fuzzy membership function core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fuzzy_membership_function_core_assert.svh"

module fmf_checker #(
    parameter int DEGREE_FRAC_BITS = fmf_pkg::DEGREE_FRAC_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [DEGREE_FRAC_BITS:0]    o_degree,
    input logic [1:0]                   o_segment
);

    localparam logic [DEGREE_FRAC_BITS:0] DEG_ONE = (DEGREE_FRAC_BITS+1)'(1) << DEGREE_FRAC_BITS;

    logic seg_out, seg_top;

    assign seg_out  = o_valid && (o_segment == fmf_pkg::SEG_OUTSIDE);
    assign seg_top  = o_valid && (o_segment == fmf_pkg::SEG_TOP);

    // output beat holds while stalled
    `FMF_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_degree) && $stable(o_segment))
    // input side backs up only behind a stalled output beat
    `FMF_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)
    `FMF_ASSERT_IMP(a_deg_max, o_valid, o_degree <= DEG_ONE)
    `FMF_ASSERT_IMP(a_outside_zero, seg_out, o_degree == '0)
    `FMF_ASSERT_IMP(a_top_one, seg_top, o_degree == DEG_ONE)

endmodule

bind fuzzy_membership_function_core fmf_checker #(
    .DEGREE_FRAC_BITS (DEGREE_FRAC_BITS)
) u_fmf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_degree  (o_degree),
    .o_segment (o_segment)
);
